[hdl/tlik_pkg.sv]
// ----------------------------------------------------------------------------
// tlik_pkg: shared types and constants for the two-link leg solver
// Datapath widths, angle constants, the CORDIC angle table and the
// side-band records that travel next to the arithmetic pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

  // CORDIC vector width and angle accumulator width (2^-30 rad)
  localparam int CW = 40;
  localparam int AW = 36;

  // Field widths
  localparam int PW = 18;
  localparam int LW = 17;
  localparam int OW = 19;

  // Square root steps (one result bit per stage) and scaler depth
  localparam int SQ_STEPS  = 32;
  localparam int SCALE_LAT = 6;

  // pi and pi/2 in 2^-30 rad
  localparam logic signed [AW-1:0] PI_Q30  = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI = 36'sd1686629713;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_UPPER = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_HIP   = 2'd2;
  localparam logic [1:0] REG_KNEE  = 2'd3;

  // Valid bit and out-of-reach flag
  typedef struct packed {
    logic valid;
    logic unr;
  } side_t;

  // Request data that rides along with the square root
  typedef struct packed {
    logic                 valid;
    logic                 unr;
    logic signed [CW-1:0] np;
    logic signed [CW-1:0] ng;
    logic signed [PW-1:0] fx;
    logic signed [PW-1:0] fz;
  } isq_side_t;

  // atan(2^-i) in 2^-30 rad, truncated
  function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0:  v = 36'sh03243F6A8;
      5'd1:  v = 36'sh01DAC6705;
      5'd2:  v = 36'sh00FADBAFC;
      5'd3:  v = 36'sh007F56EA6;
      5'd4:  v = 36'sh003FEAB76;
      5'd5:  v = 36'sh001FFD55B;
      5'd6:  v = 36'sh000FFFAAA;
      5'd7:  v = 36'sh0007FFF55;
      5'd8:  v = 36'sh0003FFFEA;
      5'd9:  v = 36'sh0001FFFFD;
      5'd10: v = 36'sh0000FFFFF;
      5'd11: v = 36'sh00007FFFF;
      5'd12: v = 36'sh00003FFFF;
      5'd13: v = 36'sh00001FFFF;
      5'd14: v = 36'sh00000FFFF;
      5'd15: v = 36'sh000007FFF;
      5'd16: v = 36'sh000003FFF;
      5'd17: v = 36'sh000001FFF;
      5'd18: v = 36'sh000000FFF;
      5'd19: v = 36'sh0000007FF;
      5'd20: v = 36'sh0000003FF;
      5'd21: v = 36'sh0000001FF;
      5'd22: v = 36'sh0000000FF;
      5'd23: v = 36'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Position of the highest set bit plus one
  function automatic logic [5:0] bitlen37(input logic [36:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 37; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

[hdl/tlik_cordic.sv]
// ----------------------------------------------------------------------------
// tlik_cordic: pipelined vectoring CORDIC, atan2(y, x)
// One quadrant pre-rotation stage, then one micro-rotation per stage.
// Result in 2^-30 rad; atan2(0, 0) gives zero.
// ----------------------------------------------------------------------------
module tlik_cordic #(
  parameter int STAGES = 16
) (
  input  logic                          clk,
  input  logic signed [tlik_pkg::CW-1:0] y_in,
  input  logic signed [tlik_pkg::CW-1:0] x_in,
  output logic signed [tlik_pkg::AW-1:0] angle
);
  import tlik_pkg::*;

  logic signed [CW-1:0] xs  [STAGES+1];
  logic signed [CW-1:0] ys  [STAGES+1];
  logic signed [AW-1:0] acc [STAGES+1];
  logic                 zf  [STAGES+1];

  // Pre-rotate into the right half plane
  always_ff @(posedge clk) begin
    zf[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        xs[0]  <= y_in;
        ys[0]  <= -x_in;
        acc[0] <= HALF_PI;
      end else begin
        xs[0]  <= -y_in;
        ys[0]  <= x_in;
        acc[0] <= -HALF_PI;
      end
    end else begin
      xs[0]  <= x_in;
      ys[0]  <= y_in;
      acc[0] <= '0;
    end
  end

  // Drive y toward zero, one shift per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      zf[i+1] <= zf[i];
      if (ys[i] >= 0) begin
        xs[i+1]  <= xs[i] + (ys[i] >>> i);
        ys[i+1]  <= ys[i] - (xs[i] >>> i);
        acc[i+1] <= acc[i] + atan_q30(5'(i));
      end else begin
        xs[i+1]  <= xs[i] - (ys[i] >>> i);
        ys[i+1]  <= ys[i] + (xs[i] >>> i);
        acc[i+1] <= acc[i] - atan_q30(5'(i));
      end
    end
  end

  assign angle = zf[STAGES] ? '0 : acc[STAGES];

endmodule

[hdl/tlik_scale.sv]
// ----------------------------------------------------------------------------
// tlik_scale: angle to motor units
// Subtracts the mount offset (1/256 degree), rescales 2^-30 rad to
// 2^-FRAC_BITS rad with round half up, and saturates to 19 bits.
// ----------------------------------------------------------------------------
module tlik_scale #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic signed [tlik_pkg::AW-1:0] a,
  input  logic signed [tlik_pkg::LW-1:0] offset,
  output logic signed [tlik_pkg::OW-1:0] result
);
  import tlik_pkg::*;

  localparam int NUM_W = 54;
  localparam int SHIFT = 40 - FRAC_BITS;
  localparam logic signed [NUM_W-1:0] DEG   = 54'sd46080;
  localparam logic signed [NUM_W-1:0] PI_N  = NUM_W'(PI_Q30);
  localparam logic signed [NUM_W-1:0] BIAS  = 54'sd45 <<< (SHIFT - 1);
  localparam logic signed [NUM_W-1:0] T_MIN = -54'sd11796480;
  localparam logic signed [NUM_W-1:0] T_MAX = 54'sd11796479;
  localparam logic [24:0]             DIV_M = 25'd23860929;
  localparam logic [24:0]             DIV_C = 25'd45;

  logic signed [NUM_W-1:0] a_ext, off_ext, mul_a, mul_o, num, t2, t2c;
  logic [24:0]             u, u4, rem;
  logic [49:0]             prod;
  logic [OW-1:0]           q0, q0w, qs;
  logic                    ge;

  assign a_ext   = NUM_W'(a);
  assign off_ext = NUM_W'(offset);

  // Clamp the floor-shifted value so the quotient lands in the output range
  always_comb begin
    t2 = num >>> SHIFT;
    if (t2 > T_MAX) begin
      t2c = T_MAX;
    end else if (t2 < T_MIN) begin
      t2c = T_MIN;
    end else begin
      t2c = t2;
    end
  end

  assign q0w = prod[48:30];
  assign rem = u4 - 25'(25'(q0w) * DIV_C);
  assign qs  = q0 + OW'(ge);

  // Multiply, bias, shift, divide by 45 through a reciprocal, correct
  always_ff @(posedge clk) begin
    mul_a  <= a_ext * DEG;
    mul_o  <= off_ext * PI_N;
    num    <= mul_a - mul_o + BIAS;
    u      <= 25'(t2c - T_MIN);
    prod   <= 50'(u) * 50'(DIV_M);
    u4     <= u;
    q0     <= q0w;
    ge     <= rem >= DIV_C;
    result <= {~qs[OW-1], qs[OW-2:0]};
  end

endmodule

[hdl/two_link_inverse_kinematics.sv]
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics: two-link planar leg solver
// Foot target (x, z) in, hip and knee motor angles out, with an
// out-of-reach flag. Fully pipelined.
//
//   channel   handshake        payload
//   request   start / busy     foot_x, foot_z
//   result    done (strobe)    hip_target, knee_target, unreachable
//   config    cfg_wen          cfg_index, cfg_data
//
// One request enters every cycle; busy stays low. The result strobes once
// the request has passed the front stages, the 32-stage square root, the
// CORDIC lanes, the combine and scaler stages and the result register. The
// pipeline never stalls: done is a one-cycle strobe. rst clears the valid
// bits and loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [tlik_pkg::PW-1:0] foot_x,
  input  logic signed [tlik_pkg::PW-1:0] foot_z,
  input  logic                          cfg_wen,
  input  logic [1:0]                    cfg_index,
  input  logic [tlik_pkg::LW-1:0]        cfg_data,
  output logic                          done,
  output logic signed [tlik_pkg::OW-1:0] hip_target,
  output logic signed [tlik_pkg::OW-1:0] knee_target,
  output logic                          unreachable
);
  import tlik_pkg::*;

  logic [LW-1:0]        upper_len, lower_len;
  logic signed [LW-1:0] hip_off, knee_off;

  assign busy = 1'b0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= 17'd13107;
      lower_len <= 17'd13107;
      hip_off   <= '0;
      knee_off  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_UPPER: upper_len <= cfg_data;
        REG_LOWER: lower_len <= cfg_data;
        REG_HIP:   hip_off   <= cfg_data;
        REG_KNEE:  knee_off  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits of the front stages
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic s4_unr, s5_unr, s6_unr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      s1_v <= start & ~busy;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  // Stage 1: squares and link product
  logic [34:0]          s1_xx, s1_zz;
  logic [33:0]          s1_l1sq, s1_l2sq, s1_l12;
  logic signed [PW-1:0] s1_fx, s1_fz;

  always_ff @(posedge clk) begin
    s1_xx   <= 35'(foot_x * foot_x);
    s1_zz   <= 35'(foot_z * foot_z);
    s1_l1sq <= 34'(upper_len * upper_len);
    s1_l2sq <= 34'(lower_len * lower_len);
    s1_l12  <= 34'(upper_len * lower_len);
    s1_fx   <= foot_x;
    s1_fz   <= foot_z;
  end

  // Stage 2: d^2 and the annulus bounds
  logic [35:0]          s2_d2;
  logic [34:0]          s2_s2, s2_lo2;
  logic [36:0]          s2_hi2;
  logic signed [35:0]   s2_dl;
  logic signed [PW-1:0] s2_fx, s2_fz;

  always_ff @(posedge clk) begin
    s2_d2  <= 36'(s1_xx) + 36'(s1_zz);
    s2_s2  <= 35'(s1_l1sq) + 35'(s1_l2sq);
    s2_hi2 <= 37'(s1_l1sq) + 37'(s1_l2sq) + 37'({s1_l12, 1'b0});
    s2_lo2 <= 35'(s1_l1sq) + 35'(s1_l2sq) - 35'({s1_l12, 1'b0});
    s2_dl  <= 36'(s1_l1sq) - 36'(s1_l2sq);
    s2_fx  <= s1_fx;
    s2_fz  <= s1_fz;
  end

  // Stage 3: reach check, Heron factors and cosine numerators
  logic                 s3_unr;
  logic [36:0]          s3_p, s3_q;
  logic signed [37:0]   s3_npf, s3_ngf;
  logic signed [PW-1:0] s3_fx, s3_fz;

  always_ff @(posedge clk) begin
    s3_unr <= (s2_d2 == '0) || (37'(s2_d2) > s2_hi2) || (36'(s2_lo2) > s2_d2);
    s3_p   <= 37'(s2_d2) - 37'(s2_lo2);
    s3_q   <= s2_hi2 - 37'(s2_d2);
    s3_npf <= 38'(s2_s2) - 38'(s2_d2);
    s3_ngf <= 38'(s2_dl) + 38'(s2_d2);
    s3_fx  <= s2_fx;
    s3_fz  <= s2_fz;
  end

  // Stage 4: pick the shift that keeps the Heron product in 64 bits
  logic [6:0]           bsum;
  logic [2:0]           s4_k;
  logic [36:0]          s4_p, s4_q;
  logic signed [37:0]   s4_npf, s4_ngf;
  logic signed [PW-1:0] s4_fx, s4_fz;

  assign bsum = 7'(bitlen37(s3_p)) + 7'(bitlen37(s3_q));

  always_ff @(posedge clk) begin
    s4_k   <= (bsum > 7'd64) ? 3'((bsum - 7'd63) >> 1) : 3'd0;
    s4_unr <= s3_unr;
    s4_p   <= s3_p;
    s4_q   <= s3_q;
    s4_npf <= s3_npf;
    s4_ngf <= s3_ngf;
    s4_fx  <= s3_fx;
    s4_fz  <= s3_fz;
  end

  // Stage 5: shift and form partial products
  logic [36:0]          pk, qk;
  logic [37:0]          s5_ll;
  logic [36:0]          s5_lh, s5_hl;
  logic [35:0]          s5_hh;
  logic signed [CW-1:0] s5_np, s5_ng;
  logic signed [PW-1:0] s5_fx, s5_fz;

  assign pk = s4_p >> s4_k;
  assign qk = s4_q >> s4_k;

  always_ff @(posedge clk) begin
    s5_ll  <= 38'(pk[18:0]) * 38'(qk[18:0]);
    s5_lh  <= 37'(pk[18:0]) * 37'(qk[36:19]);
    s5_hl  <= 37'(pk[36:19]) * 37'(qk[18:0]);
    s5_hh  <= 36'(pk[36:19]) * 36'(qk[36:19]);
    s5_np  <= CW'(s4_npf >>> s4_k);
    s5_ng  <= CW'(s4_ngf >>> s4_k);
    s5_unr <= s4_unr;
    s5_fx  <= s4_fx;
    s5_fz  <= s4_fz;
  end

  // Stage 6: sum the partial products
  logic [63:0]          s6_n;
  logic signed [CW-1:0] s6_np, s6_ng;
  logic signed [PW-1:0] s6_fx, s6_fz;

  always_ff @(posedge clk) begin
    s6_n   <= (64'(s5_hh) << 38) + (64'(s5_hl) << 19) + (64'(s5_lh) << 19) + 64'(s5_ll);
    s6_unr <= s5_unr;
    s6_np  <= s5_np;
    s6_ng  <= s5_ng;
    s6_fx  <= s5_fx;
    s6_fz  <= s5_fz;
  end

  // Square root, one result bit per stage
  logic [63:0] sq_n  [SQ_STEPS+1];
  logic [63:0] sq_r  [SQ_STEPS+1];
  isq_side_t   sq_sd [SQ_STEPS+1];

  assign sq_n[0]  = s6_n;
  assign sq_r[0]  = '0;
  assign sq_sd[0] = '{valid: s6_v, unr: s6_unr, np: s6_np, ng: s6_ng, fx: s6_fx, fz: s6_fz};

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    always_ff @(posedge clk) begin
      if (sq_n[i] >= sq_r[i] + BIT) begin
        sq_n[i+1] <= sq_n[i] - (sq_r[i] + BIT);
        sq_r[i+1] <= (sq_r[i] >> 1) + BIT;
      end else begin
        sq_n[i+1] <= sq_n[i];
        sq_r[i+1] <= sq_r[i] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_sd[i+1] <= '0;
      end else begin
        sq_sd[i+1] <= sq_sd[i];
      end
    end
  end

  // Three atan2 lanes: knee inner angle, thigh correction, target bearing
  logic signed [CW-1:0] a4;
  logic signed [AW-1:0] phi, gam, alpha;

  assign a4 = CW'(sq_r[SQ_STEPS][31:0]);

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_phi (
    .clk   (clk),
    .y_in  (a4),
    .x_in  (sq_sd[SQ_STEPS].np),
    .angle (phi)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_gam (
    .clk   (clk),
    .y_in  (a4),
    .x_in  (sq_sd[SQ_STEPS].ng),
    .angle (gam)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_alpha (
    .clk   (clk),
    .y_in  (CW'(sq_sd[SQ_STEPS].fx)),
    .x_in  (CW'(sq_sd[SQ_STEPS].fz)),
    .angle (alpha)
  );

  // Hold valid and flag beside the CORDIC lanes
  side_t cd [CORDIC_STAGES+2];

  assign cd[0] = '{valid: sq_sd[SQ_STEPS].valid, unr: sq_sd[SQ_STEPS].unr};

  for (genvar i = 0; i <= CORDIC_STAGES; i++) begin : g_cd
    always_ff @(posedge clk) begin
      if (rst) begin
        cd[i+1] <= '0;
      end else begin
        cd[i+1] <= cd[i];
      end
    end
  end

  // Combine into hip and knee angles
  logic signed [AW-1:0] hip_a, knee_a;
  side_t                sc [SCALE_LAT+1];

  always_ff @(posedge clk) begin
    hip_a  <= alpha - gam;
    knee_a <= alpha - gam + PI_Q30 - phi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc[0] <= '0;
    end else begin
      sc[0] <= cd[CORDIC_STAGES+1];
    end
  end

  // Scale to motor units
  logic signed [OW-1:0] hip_s, knee_s;

  tlik_scale #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_hip_scale (
    .clk    (clk),
    .a      (hip_a),
    .offset (hip_off),
    .result (hip_s)
  );

  tlik_scale #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_knee_scale (
    .clk    (clk),
    .a      (knee_a),
    .offset (knee_off),
    .result (knee_s)
  );

  for (genvar i = 0; i < SCALE_LAT; i++) begin : g_sc
    always_ff @(posedge clk) begin
      if (rst) begin
        sc[i+1] <= '0;
      end else begin
        sc[i+1] <= sc[i];
      end
    end
  end

  // Result register: drop angles of out-of-reach targets
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sc[SCALE_LAT].valid;
    end
  end

  always_ff @(posedge clk) begin
    hip_target  <= sc[SCALE_LAT].unr ? '0 : hip_s;
    knee_target <= sc[SCALE_LAT].unr ? '0 : knee_s;
    unreachable <= sc[SCALE_LAT].unr;
  end

endmodule

[bench/two_link_inverse_kinematics_checker.sv]
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_checker: leg solver result checker
// Watches the request, result and register ports of the solver. It keeps
// its own copy of the link lengths and mounting offsets and predicts each
// request's hip and knee angles and reach flag. Results are compared in
// order against the oldest prediction.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic signed [tlik_pkg::PW-1:0] foot_x,
  input  logic signed [tlik_pkg::PW-1:0] foot_z,
  input  logic                           cfg_wen,
  input  logic [1:0]                     cfg_index,
  input  logic [tlik_pkg::LW-1:0]        cfg_data,
  input  logic                           done,
  input  logic signed [tlik_pkg::OW-1:0] hip_target,
  input  logic signed [tlik_pkg::OW-1:0] knee_target,
  input  logic                           unreachable,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output int                             out_of_reach
);
  import tlik_pkg::*;

  localparam int STAGES = 16;
  localparam int FRAC = 14;
  localparam longint PI_RAD = 64'sd3373259426;
  localparam longint DEG = 64'sd46080;

  typedef struct {
    logic signed [OW-1:0] hip;
    logic signed [OW-1:0] knee;
    logic                 unr;
  } angles_t;

  localparam longint ARC_TAB [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  longint upper_len, lower_len, hip_off, knee_off;
  angles_t angle_q[$];

  function automatic int width_of(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring rotation: angle of (x, y) in 2^-30 rad
  function automatic longint vector_angle(longint y, longint x);
    longint acc, t, dx, dy;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = PI_RAD / 2;
      end else begin
        x = -y; y = t; acc = -(PI_RAD / 2);
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += ARC_TAB[i];
      end else begin
        x -= dx; y += dy; acc -= ARC_TAB[i];
      end
    end
    return acc;
  endfunction

  // subtract the offset, round half up, saturate
  function automatic logic signed [OW-1:0] motor_angle(longint a, longint off);
    longint den, num, q;
    den = DEG << (30 - FRAC);
    num = a * DEG - off * PI_RAD + den / 2;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    if (q > 262143) q = 262143;
    if (q < -262144) q = -262144;
    return OW'(q);
  endfunction

  function automatic angles_t solve_leg(longint x, longint z);
    angles_t r;
    longint d2, hi2, lo2, a4, np, ng, phi, gam, alpha, hip;
    longint unsigned p, q;
    int k;
    d2 = x * x + z * z;
    hi2 = (upper_len + lower_len) * (upper_len + lower_len);
    lo2 = (upper_len - lower_len) * (upper_len - lower_len);
    r.hip = '0;
    r.knee = '0;
    r.unr = 1'b1;
    if (d2 == 0 || d2 > hi2 || d2 < lo2) return r;
    p = d2 - lo2;
    q = hi2 - d2;
    k = 0;
    while (width_of(p >> k) + width_of(q >> k) > 64) k++;
    a4 = root_floor((p >> k) * (q >> k));
    np = (upper_len * upper_len + lower_len * lower_len - d2) >>> k;
    ng = (upper_len * upper_len + d2 - lower_len * lower_len) >>> k;
    phi = vector_angle(a4, np);
    gam = vector_angle(a4, ng);
    alpha = vector_angle(x, z);
    hip = alpha - gam;
    r.hip = motor_angle(hip, hip_off);
    r.knee = motor_angle(hip + PI_RAD - phi, knee_off);
    r.unr = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH result %0d: %s got %0d want %0d", checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    angles_t want;
    if (rst) begin
      upper_len = 13107;
      lower_len = 13107;
      hip_off = 0;
      knee_off = 0;
      errors = 0;
      checked = 0;
      out_of_reach = 0;
      angle_q.delete();
    end else begin
      // mirror register writes
      if (cfg_wen) begin
        case (cfg_index)
          REG_UPPER: upper_len = longint'(cfg_data);
          REG_LOWER: lower_len = longint'(cfg_data);
          REG_HIP:   hip_off = longint'($signed(cfg_data));
          REG_KNEE:  knee_off = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      // predict each accepted request
      if (start && !busy) angle_q.push_back(solve_leg(foot_x, foot_z));
      // compare each result with the oldest prediction
      if (done) begin
        if (angle_q.size() == 0) begin
          $display("MISMATCH: result with no request outstanding");
          errors++;
        end else begin
          want = angle_q.pop_front();
          if (unreachable !== want.unr) report_mismatch("unreachable", unreachable, want.unr);
          if (hip_target !== want.hip) report_mismatch("hip_target", hip_target, want.hip);
          if (knee_target !== want.knee) report_mismatch("knee_target", knee_target, want.knee);
          if (want.unr) out_of_reach++;
        end
        checked++;
      end
    end
    pending = angle_q.size();
  end

endmodule

[bench/two_link_inverse_kinematics_test.sv]
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_test: leg solver testbench
// Drives foot targets under several link length and offset settings, with
// directed corner points first and then random targets, mostly around the reach,
// and varying request gaps. Checking is done by the checker beside the DUT.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_test;
  import tlik_pkg::*;

  localparam int LIMIT = 60000;
  localparam int DRAIN = 90;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [PW-1:0] foot_x = '0;
  logic signed [PW-1:0] foot_z = '0;
  logic cfg_wen = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [LW-1:0] cfg_data = '0;
  logic done;
  logic signed [OW-1:0] hip_target, knee_target;
  logic unreachable;
  int errors, pending, checked, out_of_reach;
  int cycles = 0;
  int sent = 0;
  int idle_pct = 0;
  longint reach = 26214;

  two_link_inverse_kinematics DUT (.*);
  two_link_inverse_kinematics_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("two_link_inverse_kinematics_test: done, errors");
      $finish;
    end
  end

  // issue one request; each cycle idles with the phase's odds first
  task automatic send_target(input longint x, input longint z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    foot_x <= PW'(x);
    foot_z <= PW'(z);
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // drain the pipeline, then load all four registers
  task automatic set_leg(input int l1, input int l2, input int hip, input int knee);
    int vals [4];
    vals = '{l1, l2, hip, knee};
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_wen <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= LW'(vals[i]);
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    reach = l1 + l2;
  endtask

  // mostly targets near the reachable annulus, some anywhere
  task automatic random_targets(input int count);
    longint r, x, z;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) != 0) begin
        r = (reach > 131071) ? 131071 : reach;
        x = longint'($urandom_range(2 * r)) - r;
        z = longint'($urandom_range(2 * r)) - r;
      end else begin
        x = $signed(18'($urandom));
        z = $signed(18'($urandom));
      end
      send_target(x, z);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner points at the default legs
    send_target(0, 0);
    send_target(131071, 131071);
    send_target(-131072, -131072);
    send_target(-131072, 131071);
    send_target(26214, 0);
    send_target(0, 26214);
    send_target(0, -26214);
    send_target(-26214, 0);
    send_target(26215, 0);
    send_target(1, 0);
    send_target(0, -1);
    send_target(-9000, -20000);
    send_target(15000, -15000);
    random_targets(60);

    // unequal legs: inner boundary and full offsets
    set_leg(20000, 10000, 46080, -46080);
    send_target(10000, 0);
    send_target(0, -9999);
    send_target(30000, 0);
    send_target(-30000, 0);
    random_targets(60);

    idle_pct = 52;
    set_leg(1, 1, -46080, 46080);
    send_target(2, 0);
    send_target(1, 1);
    send_target(0, -1);
    random_targets(50);

    idle_pct = 0;
    set_leg(131071, 131071, 17'h10000, 17'h0FFFF);
    send_target(131071, 131071);
    send_target(-131072, 0);
    random_targets(60);

    idle_pct = 19;
    set_leg(131071, 1, 0, 0);
    send_target(131070, 0);
    send_target(-131072, 0);
    random_targets(60);

    // zero-length links give degenerate triangles
    idle_pct = 52;
    set_leg(0, 30000, 1000, -2000);
    send_target(30000, 0);
    send_target(0, -30000);
    random_targets(40);

    idle_pct = 0;
    set_leg(0, 0, 0, 0);
    send_target(0, 0);
    send_target(1, 0);

    idle_pct = 19;
    set_leg(40000, 25000, $urandom_range(92160) - 46080, $urandom_range(92160) - 46080);
    random_targets(100);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("requests sent %0d, results checked %0d (%0d out of reach)",
             sent, checked, out_of_reach);
    $display("eight leg settings covered, including zero and full-range lengths");
    if (errors == 0) begin
      $display("two_link_inverse_kinematics_test: done, clean");
    end else begin
      $display("two_link_inverse_kinematics_test: done, errors");
    end
    $finish;
  end

endmodule
